@@ rtl/lws_pkg.sv @@
// lws_pkg: widths, types and reset constants for the lookahead waypoint selector
// no dependencies; used by the interfaces and by lookahead_waypoint_select
`default_nettype none

package lws_pkg;

    // coordinate and distance widths
    localparam int COORD_WIDTH   = 16;
    localparam int DIST_WIDTH    = 2 * COORD_WIDTH;
    localparam int LA_WIDTH      = 16;
    localparam int LA_SQ_WIDTH   = 2 * LA_WIDTH;
    localparam int CMP_WIDTH     = (DIST_WIDTH > LA_SQ_WIDTH) ? DIST_WIDTH : LA_SQ_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [DIST_WIDTH-1:0]  dist_t;
    typedef logic        [LA_WIDTH-1:0]    la_t;
    typedef logic        [LA_SQ_WIDTH-1:0] la_sq_t;
    typedef logic        [CMP_WIDTH-1:0]   cmp_t;

    // lookahead radius after reset, 2.0 m in Q8.8
    localparam int     LOOKAHEAD_RESET_INT = 512;
    localparam la_sq_t LA_SQ_RESET         = LA_SQ_WIDTH'(LOOKAHEAD_RESET_INT * LOOKAHEAD_RESET_INT);

    // saturation bounds and the empty nearest distance
    localparam coord_t COORD_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam coord_t COORD_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam dist_t  DIST_EMPTY = {DIST_WIDTH{1'b1}};

endpackage

`default_nettype wire

@@ rtl/lws_if.sv @@
// lws_if: valid/ready channels for path points, goals and the lookahead register
// depends on lws_pkg for field types
`default_nettype none

interface lws_point_if;
    import lws_pkg::*;
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    logic   last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface lws_goal_if;
    import lws_pkg::*;
    logic   valid;
    logic   ready;
    coord_t goal_forward;
    coord_t goal_left;
    logic   used_path_end;

    modport source (output valid, goal_forward, goal_left, used_path_end, input ready);
    modport sink   (input valid, goal_forward, goal_left, used_path_end, output ready);
endinterface

interface lws_cfg_if;
    import lws_pkg::*;
    logic valid;
    logic ready;
    la_t  lookahead_distance;

    modport source (output valid, lookahead_distance, input ready);
    modport sink   (input valid, lookahead_distance, output ready);
endinterface

`default_nettype wire

@@ rtl/lookahead_waypoint_select.sv @@
// lookahead_waypoint_select: streaming pure-pursuit lookahead point selection
// depends on lws_pkg and the channel interfaces in lws_if.sv
// a last point's goal word is formed from the input register and held in the result register
// throughput: one point per cycle; the input register holds a last point only while
// the goal register is full and not taken
// reset: path state empty, no words held, lookahead radius 2.0 m
`default_nettype none

module lookahead_waypoint_select (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lws_point_if.sink  point,
    lws_goal_if.source goal,
    lws_cfg_if.sink    cfg
);
    import lws_pkg::*;

    // input register
    logic   in_valid_reg;
    coord_t x_reg;
    coord_t y_reg;
    logic   last_reg;

    // path state
    dist_t  nearest_reg, nearest_next;
    logic   found_reg, found_next;
    coord_t gx_reg, gx_next;
    coord_t gy_reg, gy_next;

    // squared lookahead radius
    la_sq_t la_sq_reg;

    // result register
    logic   out_valid_reg;
    coord_t fwd_reg, fwd_next;
    coord_t left_reg, left_next;
    logic   end_reg, end_next;

    logic advance;
    logic out_free;

    logic signed [DIST_WIDTH-1:0] x_ext;
    logic signed [DIST_WIDTH-1:0] y_ext;
    dist_t  sq_x;
    dist_t  sq_y;
    dist_t  d2;
    logic   reaches;
    coord_t cx;
    coord_t cy;

    // handshake: a last point needs a free result slot
    assign out_free    = !out_valid_reg || goal.ready;
    assign advance     = in_valid_reg && (!last_reg || out_free);
    assign point.ready = !in_valid_reg || advance;
    assign cfg.ready   = 1'b1;

    // squared distance and lookahead test
    always_comb
    begin
        x_ext   = DIST_WIDTH'(x_reg);
        y_ext   = DIST_WIDTH'(y_reg);
        sq_x    = dist_t'(x_ext * x_ext);
        sq_y    = dist_t'(y_ext * y_ext);
        d2      = sq_x + sq_y;
        reaches = CMP_WIDTH'(d2) >= CMP_WIDTH'(la_sq_reg);
    end

    // nearest point tracking and goal choice
    always_comb
    begin
        nearest_next = nearest_reg;
        found_next   = found_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        if (d2 < nearest_reg)
        begin
            nearest_next = d2;
            found_next   = reaches;
            gx_next      = reaches ? x_reg : '0;
            gy_next      = reaches ? y_reg : '0;
        end
        else if (!found_reg && reaches)
        begin
            found_next = 1'b1;
            gx_next    = x_reg;
            gy_next    = y_reg;
        end

        // chosen point, rotated to forward/left
        cx        = found_next ? gx_next : x_reg;
        cy        = found_next ? gy_next : y_reg;
        end_next  = !found_next;
        fwd_next  = cy;
        left_next = (cx == COORD_MIN) ? COORD_MAX : coord_t'(-cx);
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (point.ready)
        begin
            in_valid_reg <= point.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (point.ready && point.valid)
        begin
            x_reg    <= point.point_x;
            y_reg    <= point.point_y;
            last_reg <= point.last_point;
        end
    end

    // path state, cleared after each last point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nearest_reg <= DIST_EMPTY;
            found_reg   <= 1'b0;
            gx_reg      <= '0;
            gy_reg      <= '0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                nearest_reg <= DIST_EMPTY;
                found_reg   <= 1'b0;
                gx_reg      <= '0;
                gy_reg      <= '0;
            end
            else
            begin
                nearest_reg <= nearest_next;
                found_reg   <= found_next;
                gx_reg      <= gx_next;
                gy_reg      <= gy_next;
            end
        end
    end

    // lookahead register, kept squared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_sq_reg <= LA_SQ_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            la_sq_reg <= la_sq_t'(la_sq_t'(cfg.lookahead_distance)
                                  * la_sq_t'(cfg.lookahead_distance));
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            fwd_reg  <= fwd_next;
            left_reg <= left_next;
            end_reg  <= end_next;
        end
    end

    assign goal.valid         = out_valid_reg;
    assign goal.goal_forward  = fwd_reg;
    assign goal.goal_left     = left_reg;
    assign goal.used_path_end = end_reg;

    // a last point always produces a goal word
    a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> out_valid_reg)
        else $error("last point did not produce a goal word");

    // path state is empty after a last point
    a_path_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> !found_reg && nearest_reg == DIST_EMPTY)
        else $error("path state not cleared after last point");

    // no goal held means held coordinates are zero
    a_goal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !found_reg |-> gx_reg == '0 && gy_reg == '0)
        else $error("goal coordinates held without a goal");

    // input stalls only behind a full, untaken result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !point.ready |-> in_valid_reg && last_reg && out_valid_reg && !goal.ready)
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
